### hdl/rgs_pkg.sv
// shared widths, codes and payload types for the raster grid sampler
`default_nettype none
package rgs_pkg;

  // field widths
  localparam int XW = 29;
  localparam int YW = 28;
  localparam int VW = 32;
  localparam int CNTW = 9;
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 29;

  // divider geometry: integer quotient bits, then fraction bits
  localparam int DW = 29;
  localparam int FB = 16;
  localparam int QW = DW + FB;
  localparam int WW = 2 * FB + 1;

  localparam logic [FB:0] FRAC_ONE = (FB + 1)'(1) << FB;

  // item operations
  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_NEAREST  = 2'd1;
  localparam logic [1:0] OP_BILINEAR = 2'd2;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  // register indexes
  localparam logic [CFG_IW-1:0] REG_BOX_LEFT     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_BOX_RIGHT    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BOX_BOTTOM   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_BOX_TOP      = 3'd3;
  localparam logic [CFG_IW-1:0] REG_COLUMN_PITCH = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ROW_PITCH    = 3'd5;
  localparam logic [CFG_IW-1:0] REG_COLUMNS_USED = 3'd6;
  localparam logic [CFG_IW-1:0] REG_ROWS_USED    = 3'd7;

  // side data that rides along the divider stages
  typedef struct packed {
    logic [1:0]           op;
    logic                 in_box;
    logic [7:0]           col;
    logic [7:0]           row;
    logic signed [VW-1:0] value;
  } side_t;

endpackage
`default_nettype wire

### hdl/rgs_if.sv
// item, result and configuration channel interfaces
`default_nettype none
interface rgs_item_if;
  import rgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic signed [XW-1:0] query_x;
  logic signed [YW-1:0] query_y;
  logic [7:0]           cell_column;
  logic [7:0]           cell_row;
  logic signed [VW-1:0] cell_value;
  modport source (output valid, op, query_x, query_y, cell_column, cell_row, cell_value,
                  input ready);
  modport sink (input valid, op, query_x, query_y, cell_column, cell_row, cell_value,
                output ready);
endinterface

interface rgs_result_if;
  import rgs_pkg::*;
  logic                 valid;
  logic                 ready;
  logic signed [VW-1:0] sample;
  logic                 valid_res;
  modport source (output valid, sample, valid_res, input ready);
  modport sink (input valid, sample, valid_res, output ready);
endinterface

interface rgs_cfg_if;
  import rgs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### hdl/rgs_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module rgs_div (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [rgs_pkg::DW-1:0] num,
  input  wire logic [rgs_pkg::DW-1:0] den,
  output logic      [rgs_pkg::QW-1:0] quo,
  output logic      [rgs_pkg::DW-1:0] mid_rem
);
  import rgs_pkg::*;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] num_q [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] mid_q [FB];

  logic [DW-1:0] rem_src [QW];
  logic [QW-1:0] num_src [QW];
  logic [QW-1:0] quo_src [QW];
  logic [DW-1:0] rem_next [QW];
  logic [QW-1:0] num_next [QW];
  logic [QW-1:0] quo_next [QW];

  // stage sources: the first stage takes the dividend scaled by the fraction bits
  always_comb begin
    rem_src[0] = '0;
    num_src[0] = {num, {FB{1'b0}}};
    quo_src[0] = '0;
    for (int j = 1; j < QW; j++) begin
      rem_src[j] = rem_q[j-1];
      num_src[j] = num_q[j-1];
      quo_src[j] = quo_q[j-1];
    end
  end

  // one trial subtraction per stage
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      logic [DW:0] trial;
      logic        ge;
      trial = {rem_src[j], num_src[j][QW-1]};
      ge = trial >= {1'b0, den};
      rem_next[j] = ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      num_next[j] = num_src[j] << 1;
      quo_next[j] = {quo_src[j][QW-2:0], ge};
    end
  end

  // stage registers, and the integer remainder carried to the end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_next[j];
        num_q[j] <= num_next[j];
        quo_q[j] <= quo_next[j];
      end
      mid_q[0] <= rem_q[DW-1];
      for (int k = 1; k < FB; k++) begin
        mid_q[k] <= mid_q[k-1];
      end
    end
  end

  assign quo = quo_q[QW-1];
  assign mid_rem = mid_q[FB-1];

endmodule
`default_nettype wire

### hdl/raster_grid_sampler_top.sv
// raster grid sampler: grid store with nearest and bilinear point queries
// throughput: one item per cycle while no result waits, set by the 45-stage divider pipelines
// bilinear reads come from four identical grid copies, one read port each
// reset clears the pipeline valid bits and the configuration registers; grid cells are not cleared
// a stalled result freezes the whole pipeline in place
`default_nettype none
module raster_grid_sampler_top #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS = 256
) (
  input wire logic     clk,
  input wire logic     rst,
  rgs_item_if.sink     item,
  rgs_result_if.source result,
  rgs_cfg_if.sink      cfg
);
  import rgs_pkg::*;

  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = $clog2(DEPTH);

  typedef struct packed {
    logic                 vld;
    logic [1:0]           op;
    logic                 in_box;
    logic [3:0][AW-1:0]   addr;
    logic [FB-1:0]        fx;
    logic [FB-1:0]        fy;
    logic                 wen;
    logic [AW-1:0]        waddr;
    logic signed [VW-1:0] value;
  } p1_t;

  typedef struct packed {
    logic             vld;
    logic [1:0]       op;
    logic             in_box;
    logic [3:0][WW-1:0] w;
  } p2_t;

  typedef struct packed {
    logic                  vld;
    logic [1:0]            op;
    logic                  in_box;
    logic signed [VW-1:0]  near;
    logic [3:0][63:0]      prod;
  } p3_t;

  typedef struct packed {
    logic                 vld;
    logic [1:0]           op;
    logic                 in_box;
    logic signed [VW-1:0] near;
    logic signed [63:0]   s01;
    logic signed [63:0]   s23;
  } p4_t;

  typedef struct packed {
    logic                 vld;
    logic [1:0]           op;
    logic                 in_box;
    logic signed [VW-1:0] near;
    logic signed [63:0]   acc;
  } p5_t;

  // configuration registers
  logic signed [XW-1:0] box_left, box_right;
  logic signed [YW-1:0] box_bottom, box_top;
  logic [DW-1:0]        column_pitch;
  logic [YW-1:0]        row_pitch;
  logic [CNTW-1:0]      columns_used, rows_used;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_left <= '0;
      box_right <= '0;
      box_bottom <= '0;
      box_top <= '0;
      column_pitch <= DW'(1);
      row_pitch <= YW'(1);
      columns_used <= CNTW'(256);
      rows_used <= CNTW'(256);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BOX_LEFT:     box_left <= cfg.data;
        REG_BOX_RIGHT:    box_right <= cfg.data;
        REG_BOX_BOTTOM:   box_bottom <= cfg.data[YW-1:0];
        REG_BOX_TOP:      box_top <= cfg.data[YW-1:0];
        REG_COLUMN_PITCH: column_pitch <= cfg.data;
        REG_ROW_PITCH:    row_pitch <= cfg.data[YW-1:0];
        REG_COLUMNS_USED: columns_used <= cfg.data[CNTW-1:0];
        REG_ROWS_USED:    rows_used <= cfg.data[CNTW-1:0];
        default: ;
      endcase
    end
  end

  // effective pitches and last usable indexes
  logic [DW-1:0] pitch_x, pitch_y;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  always_comb begin
    int ec, er;
    pitch_x = (column_pitch == '0) ? DW'(1) : column_pitch;
    pitch_y = (row_pitch == '0) ? DW'(1) : DW'(row_pitch);
    if (columns_used == '0) ec = 1;
    else if (int'(columns_used) > MAX_COLUMNS) ec = MAX_COLUMNS;
    else ec = int'(columns_used);
    if (rows_used == '0) er = 1;
    else if (int'(rows_used) > MAX_ROWS) er = MAX_ROWS;
    else er = int'(rows_used);
    last_col = CW'(ec - 1);
    last_row = RW'(er - 1);
  end

  // the whole pipeline moves unless a result waits
  logic adv;
  assign adv = !result.valid || result.ready;
  assign item.ready = adv;

  // entry: box test and offsets from the left and top edges
  logic          in_box;
  logic [XW:0]   dx_wide;
  logic [YW:0]   dy_wide;
  logic [DW-1:0] dx, dy;

  always_comb begin
    in_box = (item.query_x >= box_left) && (item.query_x <= box_right) &&
             (item.query_y >= box_bottom) && (item.query_y <= box_top);
    dx_wide = {item.query_x[XW-1], item.query_x} - {box_left[XW-1], box_left};
    dy_wide = {box_top[YW-1], box_top} - {item.query_y[YW-1], item.query_y};
    dx = dx_wide[DW-1:0];
    dy = DW'(dy_wide[YW-1:0]);
  end

  // dividers for both axes
  logic [QW-1:0] quo_x, quo_y;
  logic [DW-1:0] rem_x, rem_y;

  rgs_div u_div_x (
    .clk     (clk),
    .en      (adv),
    .num     (dx),
    .den     (pitch_x),
    .quo     (quo_x),
    .mid_rem (rem_x)
  );

  rgs_div u_div_y (
    .clk     (clk),
    .en      (adv),
    .num     (dy),
    .den     (pitch_y),
    .quo     (quo_y),
    .mid_rem (rem_y)
  );

  // side line alongside the divider stages
  logic  vld_q [QW];
  side_t side_q [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < QW; j++) vld_q[j] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= item.valid && (item.op != OP_UNUSED);
      for (int j = 1; j < QW; j++) vld_q[j] <= vld_q[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0].op <= item.op;
      side_q[0].in_box <= in_box;
      side_q[0].col <= item.cell_column;
      side_q[0].row <= item.cell_row;
      side_q[0].value <= item.cell_value;
      for (int j = 1; j < QW; j++) side_q[j] <= side_q[j-1];
    end
  end

  function automatic logic [CW-1:0] clamp_col(input logic [DW:0] i, input logic [CW-1:0] last);
    return (i > (DW + 1)'(last)) ? last : i[CW-1:0];
  endfunction

  function automatic logic [RW-1:0] clamp_row(input logic [DW:0] i, input logic [RW-1:0] last);
    return (i > (DW + 1)'(last)) ? last : i[RW-1:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * MAX_COLUMNS + int'(c));
  endfunction

  // stage 1: indexes, clamping and addresses
  p1_t p1, p1_next;

  always_comb begin
    logic [DW-1:0] qx, qy;
    logic [DW:0]   cx, cy;
    logic [CW-1:0] col_n, col_l, col_r;
    logic [RW-1:0] row_n, row_t, row_b;
    side_t         s;
    s = side_q[QW-1];
    qx = quo_x[QW-1:FB];
    qy = quo_y[QW-1:FB];
    cx = {1'b0, qx} + (DW + 1)'({rem_x, 1'b0} > {1'b0, pitch_x});
    cy = {1'b0, qy} + (DW + 1)'({rem_y, 1'b0} > {1'b0, pitch_y});
    col_n = clamp_col(cx, last_col);
    row_n = clamp_row(cy, last_row);
    col_l = clamp_col({1'b0, qx}, last_col);
    col_r = clamp_col({1'b0, qx} + (DW + 1)'(1), last_col);
    row_t = clamp_row({1'b0, qy}, last_row);
    row_b = clamp_row({1'b0, qy} + (DW + 1)'(1), last_row);
    p1_next.vld = vld_q[QW-1];
    p1_next.op = s.op;
    p1_next.in_box = s.in_box;
    p1_next.addr[0] = (s.op == OP_NEAREST) ? cell_addr(row_n, col_n) : cell_addr(row_t, col_l);
    p1_next.addr[1] = cell_addr(row_t, col_r);
    p1_next.addr[2] = cell_addr(row_b, col_l);
    p1_next.addr[3] = cell_addr(row_b, col_r);
    p1_next.fx = quo_x[FB-1:0];
    p1_next.fy = quo_y[FB-1:0];
    p1_next.wen = (s.op == OP_WRITE) && (int'(s.col) < MAX_COLUMNS) &&
                  (int'(s.row) < MAX_ROWS);
    p1_next.waddr = AW'(int'(s.row) * MAX_COLUMNS + int'(s.col));
    p1_next.value = s.value;
  end

  // stage 2: grid writes and reads, and blend weights
  logic [VW-1:0] mem0 [DEPTH];
  logic [VW-1:0] mem1 [DEPTH];
  logic [VW-1:0] mem2 [DEPTH];
  logic [VW-1:0] mem3 [DEPTH];
  logic [3:0][VW-1:0] rd;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (p1.vld && p1.wen) begin
        mem0[p1.waddr] <= p1.value;
        mem1[p1.waddr] <= p1.value;
        mem2[p1.waddr] <= p1.value;
        mem3[p1.waddr] <= p1.value;
      end
      rd[0] <= mem0[p1.addr[0]];
      rd[1] <= mem1[p1.addr[1]];
      rd[2] <= mem2[p1.addr[2]];
      rd[3] <= mem3[p1.addr[3]];
    end
  end

  p2_t p2, p2_next;

  always_comb begin
    logic [FB:0] gx, gy, fx, fy;
    logic [2*FB+1:0] w0, w1, w2, w3;
    fx = {1'b0, p1.fx};
    fy = {1'b0, p1.fy};
    gx = FRAC_ONE - fx;
    gy = FRAC_ONE - fy;
    w0 = gx * gy;
    w1 = fx * gy;
    w2 = gx * fy;
    w3 = fx * fy;
    p2_next.vld = p1.vld && (p1.op != OP_WRITE);
    p2_next.op = p1.op;
    p2_next.in_box = p1.in_box;
    p2_next.w[0] = w0[WW-1:0];
    p2_next.w[1] = w1[WW-1:0];
    p2_next.w[2] = w2[WW-1:0];
    p2_next.w[3] = w3[WW-1:0];
  end

  // stage 3: weighted products; a full weight is a plain shift
  p3_t p3, p3_next;

  always_comb begin
    logic signed [64:0] m;
    p3_next.vld = p2.vld;
    p3_next.op = p2.op;
    p3_next.in_box = p2.in_box;
    p3_next.near = rd[0];
    for (int k = 0; k < 4; k++) begin
      m = $signed(rd[k]) * $signed({1'b0, p2.w[k][WW-2:0]});
      p3_next.prod[k] = p2.w[k][WW-1] ? {rd[k], 32'b0} : m[63:0];
    end
  end

  // stage 4 and 5: adder tree
  p4_t p4, p4_next;
  p5_t p5, p5_next;

  always_comb begin
    p4_next.vld = p3.vld;
    p4_next.op = p3.op;
    p4_next.in_box = p3.in_box;
    p4_next.near = p3.near;
    p4_next.s01 = $signed(p3.prod[0]) + $signed(p3.prod[1]);
    p4_next.s23 = $signed(p3.prod[2]) + $signed(p3.prod[3]);
    p5_next.vld = p4.vld;
    p5_next.op = p4.op;
    p5_next.in_box = p4.in_box;
    p5_next.near = p4.near;
    p5_next.acc = p4.s01 + p4.s23;
  end

  // output: truncate toward zero and pick the result
  logic signed [VW-1:0] sample_next;

  always_comb begin
    logic signed [63:0] biased;
    biased = p5.acc + (p5.acc[63] ? 64'h0000_0000_FFFF_FFFF : 64'd0);
    if (!p5.in_box) sample_next = '0;
    else if (p5.op == OP_NEAREST) sample_next = p5.near;
    else sample_next = biased[63:32];
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p1.vld <= 1'b0;
      p2.vld <= 1'b0;
      p3.vld <= 1'b0;
      p4.vld <= 1'b0;
      p5.vld <= 1'b0;
      result.valid <= 1'b0;
    end else if (adv) begin
      p1 <= p1_next;
      p2 <= p2_next;
      p3 <= p3_next;
      p4 <= p4_next;
      p5 <= p5_next;
      result.valid <= p5.vld;
      result.sample <= sample_next;
      result.valid_res <= p5.in_box;
    end
  end

  // checks
  logic [WW+1:0] weight_sum;
  assign weight_sum = (WW + 2)'(p2.w[0]) + (WW + 2)'(p2.w[1]) +
                      (WW + 2)'(p2.w[2]) + (WW + 2)'(p2.w[3]);

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.valid_res |-> result.sample == '0)
    else $error("outside query gave nonzero sample");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.ready |=> $stable(vld_q[0]) && $stable(p5.vld) && $stable(p1.vld))
    else $error("pipeline moved during a stall");

  a_weights_unit: assert property (@(posedge clk) disable iff (rst)
    p2.vld && p2.op == OP_BILINEAR |-> weight_sum == ((WW + 2)'(1) << (2 * FB)))
    else $error("bilinear weights do not sum to one");

endmodule
`default_nettype wire
